// ===== rtl/core/key_pair_handle_table_assert.svh =====
`ifndef KEY_PAIR_HANDLE_TABLE_ASSERT_SVH
`define KEY_PAIR_HANDLE_TABLE_ASSERT_SVH

// Concurrent assertion clocked on clk_i and disabled while rst_ni is low.
`define KHTAB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assertion that an antecedent implies a consequent in the same cycle.
`define KHTAB_ASSERT_IMP(label, ante, cons, msg) \
  `KHTAB_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/khtab_pkg.sv =====
package khtab_pkg;

  localparam int OP_W  = 2;
  localparam int CAP_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

endpackage

// ===== rtl/core/key_pair_handle_table.sv =====
// Lookup, delete and allocate with the table at capacity scan the slots below the fill mark,
// one slot per cycle, then wait in ST_RESP until the output register is free.
// Allocate below capacity and a read at or past the fill mark go straight to ST_RESP, other
// reads via ST_READ. The back sequencer takes one operation at a time, and the front queue
// holds two more. Reset clears the fill mark, the live count and the handshakes;
// slots at or above the fill mark read as zero, so the slot memory needs no clearing pass.
module key_pair_handle_table import khtab_pkg::*; #(
  parameter int SLOTS     = 64,
  parameter int TYPE_BITS = 8,
  parameter int ID_BITS   = 16,
  localparam int IDX_W    = $clog2(SLOTS),
  localparam int CNT_W    = $clog2(SLOTS + 1),
  localparam int IN_W     = TYPE_BITS + ID_BITS + IDX_W,
  localparam int IN_TD_W  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W    = IDX_W + TYPE_BITS + ID_BITS + CNT_W,
  localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CAP_W-1:0]    cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // key_type, key_id, slot_index
  input  logic [IN_TD_W-1:0]  s_axis_tdata,
  // opcode
  input  logic [OP_W-1:0]     s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // result_index, out_type, out_id, live_count
  output logic [OUT_TD_W-1:0] m_axis_tdata,
  // found, table_full
  output logic [1:0]          m_axis_tuser
);

  logic [CAP_W-1:0]     cap_q;
  logic                 cmd_valid, cmd_ready;
  op_e                  cmd_op;
  logic [TYPE_BITS-1:0] cmd_type;
  logic [ID_BITS-1:0]   cmd_id;
  logic [IDX_W-1:0]     cmd_idx;
  logic [IDX_W-1:0]     rsp_index;
  logic                 rsp_found, rsp_full;
  logic [TYPE_BITS-1:0] rsp_type;
  logic [ID_BITS-1:0]   rsp_id;
  logic [CNT_W-1:0]     rsp_live;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(64);
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  khtab_front #(
    .TYPE_BITS (TYPE_BITS),
    .ID_BITS   (ID_BITS),
    .IDX_W     (IDX_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_opcode_i (s_axis_tuser),
    .in_type_i   (s_axis_tdata[TYPE_BITS-1:0]),
    .in_id_i     (s_axis_tdata[TYPE_BITS+ID_BITS-1:TYPE_BITS]),
    .in_idx_i    (s_axis_tdata[IN_W-1:TYPE_BITS+ID_BITS]),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_op_o    (cmd_op),
    .cmd_type_o  (cmd_type),
    .cmd_id_o    (cmd_id),
    .cmd_idx_o   (cmd_idx)
  );

  khtab_back #(
    .SLOTS     (SLOTS),
    .TYPE_BITS (TYPE_BITS),
    .ID_BITS   (ID_BITS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_op_i    (cmd_op),
    .cmd_type_i  (cmd_type),
    .cmd_id_i    (cmd_id),
    .cmd_idx_i   (cmd_idx),
    .rsp_valid_o (m_axis_tvalid),
    .rsp_ready_i (m_axis_tready),
    .rsp_index_o (rsp_index),
    .rsp_found_o (rsp_found),
    .rsp_full_o  (rsp_full),
    .rsp_type_o  (rsp_type),
    .rsp_id_o    (rsp_id),
    .rsp_live_o  (rsp_live)
  );

  assign m_axis_tdata = OUT_TD_W'({rsp_live, rsp_id, rsp_type, rsp_index});
  assign m_axis_tuser = {rsp_full, rsp_found};

endmodule

// ===== rtl/core/khtab_front.sv =====
module khtab_front import khtab_pkg::*; #(
  parameter int TYPE_BITS = 8,
  parameter int ID_BITS   = 16,
  parameter int IDX_W     = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OP_W-1:0]      in_opcode_i,
  input  logic [TYPE_BITS-1:0] in_type_i,
  input  logic [ID_BITS-1:0]   in_id_i,
  input  logic [IDX_W-1:0]     in_idx_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output op_e                  cmd_op_o,
  output logic [TYPE_BITS-1:0] cmd_type_o,
  output logic [ID_BITS-1:0]   cmd_id_o,
  output logic [IDX_W-1:0]     cmd_idx_o
);

  op_e                  op_q   [2];
  logic [TYPE_BITS-1:0] type_q [2];
  logic [ID_BITS-1:0]   id_q   [2];
  logic [IDX_W-1:0]     idx_q  [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           cnt_q;
  logic                 push, pop;
  op_e                  in_op;

  assign in_op       = op_e'(in_opcode_i);
  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  assign cmd_op_o   = op_q[rd_ptr_q];
  assign cmd_type_o = type_q[rd_ptr_q];
  assign cmd_id_o   = id_q[rd_ptr_q];
  assign cmd_idx_o  = idx_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_ptr_q]   <= in_op;
      type_q[wr_ptr_q] <= in_type_i;
      id_q[wr_ptr_q]   <= in_id_i;
      idx_q[wr_ptr_q]  <= (in_op == OP_READ) ? in_idx_i : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/core/khtab_back.sv =====
module khtab_back import khtab_pkg::*; #(
  parameter int SLOTS     = 64,
  parameter int TYPE_BITS = 8,
  parameter int ID_BITS   = 16,
  parameter int IDX_W     = 6,
  parameter int CNT_W     = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CAP_W-1:0]     cap_i,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  op_e                  cmd_op_i,
  input  logic [TYPE_BITS-1:0] cmd_type_i,
  input  logic [ID_BITS-1:0]   cmd_id_i,
  input  logic [IDX_W-1:0]     cmd_idx_i,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  output logic [IDX_W-1:0]     rsp_index_o,
  output logic                 rsp_found_o,
  output logic                 rsp_full_o,
  output logic [TYPE_BITS-1:0] rsp_type_o,
  output logic [ID_BITS-1:0]   rsp_id_o,
  output logic [CNT_W-1:0]     rsp_live_o
);

  localparam int KEY_W = TYPE_BITS + ID_BITS;
  localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_RESP
  } state_e;

  logic [KEY_W-1:0] mem_q [SLOTS];
  logic [KEY_W-1:0] rd_data_q;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [KEY_W-1:0] mem_wd;

  state_e                 state_q, state_d;
  op_e                    op_q, op_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [CNT_W-1:0]       fill_q, fill_d;
  logic [CNT_W-1:0]       live_q, live_d;
  logic [CNT_W-1:0]       issue_q, issue_d;
  logic                   dvld_q, dvld_d;
  logic [IDX_W-1:0]       didx_q, didx_d;
  logic [IDX_W-1:0]       res_index_q, res_index_d;
  logic                   res_found_q, res_found_d;
  logic                   res_full_q, res_full_d;
  logic [KEY_W-1:0]       res_key_q, res_key_d;
  logic                   out_valid_q, out_valid_d;
  logic [IDX_W-1:0]       out_index_q, out_index_d;
  logic                   out_found_q, out_found_d;
  logic                   out_full_q, out_full_d;
  logic [KEY_W-1:0]       out_key_q, out_key_d;
  logic [CNT_W-1:0]       out_live_q, out_live_d;

  logic             reuse;
  logic             match;
  logic             new_live;
  logic [KEY_W-1:0] cmd_key;
  logic             out_free;

  assign cmd_key  = {cmd_id_i, cmd_type_i};
  assign reuse    = (CW'(fill_q) >= CW'(cap_i)) || (fill_q == CNT_W'(SLOTS));
  assign match    = (op_q == OP_ALLOC) ? (rd_data_q[KEY_W-1:TYPE_BITS] == '0)
                                       : (rd_data_q == key_q);
  assign new_live = (key_q[KEY_W-1:TYPE_BITS] != '0);
  assign out_free = !out_valid_q || rsp_ready_i;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = out_valid_q;
  assign rsp_index_o = out_index_q;
  assign rsp_found_o = out_found_q;
  assign rsp_full_o  = out_full_q;
  assign rsp_type_o  = out_key_q[TYPE_BITS-1:0];
  assign rsp_id_o    = out_key_q[KEY_W-1:TYPE_BITS];
  assign rsp_live_o  = out_live_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_data_q <= mem_q[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    fill_d      = fill_q;
    live_d      = live_q;
    issue_d     = issue_q;
    dvld_d      = 1'b0;
    didx_d      = didx_q;
    res_index_d = res_index_q;
    res_found_d = res_found_q;
    res_full_d  = res_full_q;
    res_key_d   = res_key_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    out_index_d = out_index_q;
    out_found_d = out_found_q;
    out_full_d  = out_full_q;
    out_key_d   = out_key_q;
    out_live_d  = out_live_q;
    rd_addr     = issue_q[IDX_W-1:0];
    mem_we      = 1'b0;
    mem_wa      = fill_q[IDX_W-1:0];
    mem_wd      = cmd_key;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          op_d        = cmd_op_i;
          key_d       = cmd_key;
          issue_d     = '0;
          res_index_d = '0;
          res_found_d = 1'b0;
          res_full_d  = 1'b0;
          res_key_d   = '0;
          case (cmd_op_i)
            OP_ALLOC: begin
              if (reuse) begin
                state_d = ST_SCAN;
              end else begin
                mem_we      = 1'b1;
                res_index_d = fill_q[IDX_W-1:0];
                fill_d      = fill_q + CNT_W'(1);
                live_d      = live_q + CNT_W'(cmd_id_i != '0);
                state_d     = ST_RESP;
              end
            end
            OP_READ: begin
              rd_addr = cmd_idx_i;
              state_d = (CNT_W'(cmd_idx_i) < fill_q) ? ST_READ : ST_RESP;
            end
            default: state_d = ST_SCAN;
          endcase
        end
      end
      ST_SCAN: begin
        mem_wa = didx_q;
        if (dvld_q && match) begin
          res_index_d = didx_q;
          case (op_q)
            OP_ALLOC: begin
              mem_we = 1'b1;
              mem_wd = key_q;
              live_d = live_q + CNT_W'(new_live);
            end
            OP_DELETE: begin
              mem_we      = 1'b1;
              mem_wd      = '0;
              res_found_d = 1'b1;
              live_d      = live_q - CNT_W'(new_live);
            end
            default: res_found_d = 1'b1;
          endcase
          state_d = ST_RESP;
        end else if (issue_q == fill_q) begin
          res_full_d = (op_q == OP_ALLOC);
          state_d    = ST_RESP;
        end else begin
          dvld_d  = 1'b1;
          didx_d  = issue_q[IDX_W-1:0];
          issue_d = issue_q + CNT_W'(1);
        end
      end
      ST_READ: begin
        res_key_d = rd_data_q;
        state_d   = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_index_d = res_index_q;
          out_found_d = res_found_q;
          out_full_d  = res_full_q;
          out_key_d   = res_key_q;
          out_live_d  = live_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_LOOKUP;
      key_q       <= '0;
      fill_q      <= '0;
      live_q      <= '0;
      issue_q     <= '0;
      dvld_q      <= 1'b0;
      didx_q      <= '0;
      res_index_q <= '0;
      res_found_q <= 1'b0;
      res_full_q  <= 1'b0;
      res_key_q   <= '0;
      out_valid_q <= 1'b0;
      out_index_q <= '0;
      out_found_q <= 1'b0;
      out_full_q  <= 1'b0;
      out_key_q   <= '0;
      out_live_q  <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      key_q       <= key_d;
      fill_q      <= fill_d;
      live_q      <= live_d;
      issue_q     <= issue_d;
      dvld_q      <= dvld_d;
      didx_q      <= didx_d;
      res_index_q <= res_index_d;
      res_found_q <= res_found_d;
      res_full_q  <= res_full_d;
      res_key_q   <= res_key_d;
      out_valid_q <= out_valid_d;
      out_index_q <= out_index_d;
      out_found_q <= out_found_d;
      out_full_q  <= out_full_d;
      out_key_q   <= out_key_d;
      out_live_q  <= out_live_d;
    end
  end

endmodule

// ===== rtl/core/khtab_sva.sv =====
`include "key_pair_handle_table_assert.svh"

module khtab_sva #(
  parameter int SLOTS     = 64,
  parameter int TYPE_BITS = 8,
  parameter int ID_BITS   = 16,
  localparam int IDX_W    = $clog2(SLOTS),
  localparam int CNT_W    = $clog2(SLOTS + 1),
  localparam int OUT_W    = IDX_W + TYPE_BITS + ID_BITS + CNT_W,
  localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OUT_TD_W-1:0] m_axis_tdata,
  input logic [1:0]          m_axis_tuser
);

  logic [IDX_W-1:0] index;
  logic [CNT_W-1:0] live;

  assign index = m_axis_tdata[IDX_W-1:0];
  assign live  = m_axis_tdata[OUT_W-1:OUT_W-CNT_W];

  `KHTAB_ASSERT(a_out_held, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output transaction changed while stalled")
  `KHTAB_ASSERT_IMP(a_full_clean, m_axis_tvalid && m_axis_tuser[1], index == '0 && !m_axis_tuser[0], "full result carries an index or a hit")
  `KHTAB_ASSERT_IMP(a_live_bound, m_axis_tvalid, CNT_W'(live) <= CNT_W'(SLOTS), "live count exceeds slot count")
  `KHTAB_ASSERT_IMP(a_found_full, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]), "hit and full reported together")

endmodule

bind key_pair_handle_table khtab_sva #(
  .SLOTS     (SLOTS),
  .TYPE_BITS (TYPE_BITS),
  .ID_BITS   (ID_BITS)
) u_khtab_sva (.*);
